### rtl/crc16_pkg.sv
// Package for the configurable CRC-16 engine.
// Holds the register index codes, the index type and the byte update function.
// No dependencies.
package crc16_pkg;

  // Width of the configuration register index.
  localparam int unsigned CfgIndexWidth = 3;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;
  typedef logic [15:0] crc_t;

  // Configuration register indexes.
  localparam cfg_index_t RegPoly           = 3'd0;
  localparam cfg_index_t RegInitValue      = 3'd1;
  localparam cfg_index_t RegFinalXor       = 3'd2;
  localparam cfg_index_t RegReversePoly    = 3'd3;
  localparam cfg_index_t RegReflectedShift = 3'd4;

  // Bit masks used by the shift steps.
  localparam crc_t CrcMsbMask = 16'h8000;
  localparam crc_t CrcLsbMask = 16'h0001;

  // Mirror the bit order of a 16-bit word.
  function automatic crc_t bit_reverse16(input crc_t value);
    crc_t result;
    for (int k = 0; k < 16; k++) begin
      result[k] = value[15-k];
    end
    return result;
  endfunction

  // Fold one byte into the remainder, eight bit steps, in either direction.
  function automatic crc_t crc16_byte(input crc_t rem, input logic [7:0] data,
                                      input crc_t gen, input logic reflected);
    crc_t r;
    r = reflected ? (rem ^ {8'h00, data}) : (rem ^ {data, 8'h00});
    for (int k = 0; k < 8; k++) begin
      if (reflected) begin
        if ((r & CrcLsbMask) != 16'h0000) begin
          r = (r >> 1) ^ gen;
        end else begin
          r = r >> 1;
        end
      end else begin
        if ((r & CrcMsbMask) != 16'h0000) begin
          r = (r << 1) ^ gen;
        end else begin
          r = r << 1;
        end
      end
    end
    return r;
  endfunction

endpackage

### rtl/configurable_crc16_engine.sv
// Configurable CRC-16 engine: top level with config registers and output skid.
// Depends on crc16_pkg.
//
// Usage:
// Message bytes arrive on the s_ channel; s_tlast marks the final byte of a
// message. Each accepted beat folds the byte into a 16-bit running remainder
// in the same cycle, so one byte is taken every clock while s_tready is high.
// When the last byte is taken, its CRC (remainder XORed with final_xor) is
// registered into the output register, or into the skid register while the
// output is held; the remainder reloads init_value. No beat for other bytes.
// The cfg_ channel writes the five registers by index (0 poly, 1 init_value,
// 2 final_xor, 3 reverse_poly, 4 reflected_shift); it is always ready.
// Writing init_value also restarts the running remainder. Other indexes are
// ignored. Write only while the block is idle.
// Throughput is one byte per cycle while s_tready is high, set by the
// combinational eight-step XOR network.
// An output register plus a one-entry skid register let input continue while
// one result waits; s_tready drops only when both hold a result.
// Reset (rst, synchronous) restores the register defaults, loads the
// remainder with 0xFFFF and empties the output side.
module configurable_crc16_engine (
  input  logic                     clk,
  input  logic                     rst,
  // Input stream.
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] data_byte
  input  logic                     s_tlast,   // last_byte
  // Output stream.
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [15:0]              m_tdata,   // [15:0] crc_value
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  crc16_pkg::cfg_index_t    cfg_index,
  input  logic [15:0]              cfg_data
);

  // Configuration registers.
  crc16_pkg::crc_t poly;
  crc16_pkg::crc_t init_value;
  crc16_pkg::crc_t final_xor;
  logic            reverse_poly;
  logic            reflected_shift;

  // Running remainder and output side.
  crc16_pkg::crc_t remainder;
  crc16_pkg::crc_t remainder_next;
  crc16_pkg::crc_t gen_poly;
  crc16_pkg::crc_t crc_next;
  crc16_pkg::crc_t skid_data;
  logic            skid_valid;
  logic            in_beat;
  logic            cfg_beat;
  logic            produce;

  assign cfg_ready = 1'b1;
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign s_tready  = !skid_valid;
  assign in_beat   = s_tvalid && s_tready;
  assign produce   = in_beat && s_tlast;

  // Byte update of the remainder.
  always_comb begin
    gen_poly       = reverse_poly ? crc16_pkg::bit_reverse16(poly) : poly;
    remainder_next = crc16_pkg::crc16_byte(remainder, s_tdata, gen_poly, reflected_shift);
    crc_next       = remainder_next ^ final_xor;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly            <= 16'h8005;
      init_value      <= 16'hFFFF;
      final_xor       <= 16'h0000;
      reverse_poly    <= 1'b1;
      reflected_shift <= 1'b1;
    end else if (cfg_beat) begin
      case (cfg_index)
        crc16_pkg::RegPoly:           poly            <= cfg_data;
        crc16_pkg::RegInitValue:      init_value      <= cfg_data;
        crc16_pkg::RegFinalXor:       final_xor       <= cfg_data;
        crc16_pkg::RegReversePoly:    reverse_poly    <= cfg_data[0];
        crc16_pkg::RegReflectedShift: reflected_shift <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Running remainder: reload on the last byte or an init_value write.
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= 16'hFFFF;
    end else if (cfg_beat && (cfg_index == crc16_pkg::RegInitValue)) begin
      remainder <= cfg_data;
    end else if (in_beat) begin
      remainder <= s_tlast ? init_value : remainder_next;
    end
  end

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!m_tvalid || m_tready) begin
        m_tdata  <= crc_next;
        m_tvalid <= 1'b1;
      end else begin
        skid_data  <= crc_next;
        skid_valid <= 1'b1;
      end
    end else if (m_tvalid && m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  // A held skid entry always sits behind a valid output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds a result while the output is empty");

  // A last byte always leaves m_tvalid high in the next cycle.
  a_last_gives_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("last byte accepted without a CRC beat following");

  // Input backpressure only while a result is stuck at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && skid_valid))
    else $error("input stalled with room on the output side");
`endif

endmodule
